@@ rtl/core/kdar_pkg.sv @@
// Shared types and constants for the keypad debounce and auto-repeat block.
`default_nettype none

package kdar_pkg;

  // Field widths
  localparam int RAW_W      = 9;
  localparam int HIST_W     = 8;
  localparam int CNT_W      = 16;
  localparam int KEY_IDX_W  = 4;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_MASK    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UP_MASK      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_THR     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TURBO_THR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_RATE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TURBO_RATE   = 3'd5;

  // Configuration reset values
  localparam logic [HIST_W-1:0] DOWN_MASK_RST    = 8'h07;
  localparam logic [HIST_W-1:0] UP_MASK_RST      = 8'h07;
  localparam logic [CNT_W-1:0]  HOLD_THR_RST     = 16'd100;
  localparam logic [CNT_W-1:0]  TURBO_THR_RST    = 16'd240;
  localparam logic [CNT_W-1:0]  SLOW_RATE_RST    = 16'd40;
  localparam logic [CNT_W-1:0]  TURBO_RATE_RST   = 16'd8;

  // Event kinds
  localparam logic [KIND_W-1:0] EV_PRESS   = 2'd0;
  localparam logic [KIND_W-1:0] EV_REPEAT  = 2'd1;
  localparam logic [KIND_W-1:0] EV_RELEASE = 2'd2;

  // Per-key state word held in the state memory
  typedef struct packed {
    logic [HIST_W-1:0] hist;
    logic [CNT_W-1:0]  count;
    logic              held;
  } key_state_t;

  // Remainder unit request and response
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic done;
    logic zero;
  } mod_rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/kdar_if.sv @@
// Valid/ready channel interfaces for scan ticks and key events.
`default_nettype none

interface kdar_in_if;
  logic                       valid;
  logic                       ready;
  logic [kdar_pkg::RAW_W-1:0] raw_pressed;

  modport source (output valid, output raw_pressed, input ready);
  modport sink   (input valid, input raw_pressed, output ready);
endinterface

interface kdar_out_if;
  logic                           valid;
  logic                           ready;
  logic [kdar_pkg::KEY_IDX_W-1:0] key_id;
  logic [kdar_pkg::KIND_W-1:0]    event_kind;
  logic                           last_of_tick;

  modport source (output valid, output key_id, output event_kind, output last_of_tick,
                  input ready);
  modport sink   (input valid, input key_id, input event_kind, input last_of_tick,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/kdar_state_mem.sv @@
// Per-key state memory: one write port, one registered read port, valid bits for reset.
`default_nettype none

module kdar_state_mem #(
  parameter int NUM_KEYS = 9,
  parameter int AW       = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  kdar_pkg::key_state_t wdata_i,
  output kdar_pkg::key_state_t rdata_o
);
  import kdar_pkg::*;

  key_state_t              mem [NUM_KEYS];
  logic [NUM_KEYS-1:0]     valid_q;
  key_state_t              rd_q;
  logic                    rd_vld_q;

  // Storage array, no reset
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem[raddr_i];
    end
  end

  // Entry valid bits; an entry never written reads as all zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_vld_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

@@ rtl/core/kdar_mod_unit.sv @@
// Iterative remainder unit: one quotient bit per cycle, reports whether the remainder is zero.
`default_nettype none

module kdar_mod_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kdar_pkg::mod_req_t req_i,
  output kdar_pkg::mod_rsp_t rsp_o
);
  import kdar_pkg::*;

  localparam int SW = $clog2(CNT_W);
  localparam logic [SW-1:0] LAST_STEP = SW'(CNT_W - 1);

  logic             busy_q;
  logic [SW-1:0]    step_q;
  logic [CNT_W-1:0] rem_q;
  logic [CNT_W-1:0] dvd_q;
  logic [CNT_W-1:0] dvs_q;
  logic             done_q;
  logic             zero_q;

  logic [CNT_W:0]   trial;
  logic             ge;
  logic [CNT_W-1:0] rem_d;

  // Restoring step: bring in next dividend bit, subtract divisor if it fits
  always_comb begin
    trial = {rem_q, dvd_q[CNT_W-1]};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? CNT_W'(trial - {1'b0, dvs_q}) : trial[CNT_W-1:0];
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= dvd_q << 1;
      if (step_q == LAST_STEP) begin
        zero_q <= (rem_d == '0);
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.zero = zero_q;

endmodule

`default_nettype wire

@@ rtl/core/keypad_debounce_auto_repeat_core.sv @@
// A tick runs a per-key read/evaluate/write-back pass over the state memory; a held key at or
// past hold_threshold also waits for the 16-step remainder unit, and output stalls can hold
// the pass. Throughput: one tick at a time; the next tick is taken once the last event
// sits in the output register. Reset: config registers return to defaults, all key state
// reads as zero.
`default_nettype none

module keypad_debounce_auto_repeat_core #(
  parameter int NUM_KEYS = 9
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  kdar_in_if.sink                           tick_in,
  kdar_out_if.source                        evt_out,
  input  logic                              cfg_we_i,
  input  logic [kdar_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [kdar_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import kdar_pkg::*;

  localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam logic [AW-1:0] LAST_KEY = AW'(NUM_KEYS - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_EVAL   = 3'd2;
  localparam logic [2:0] S_MODW   = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_FLUSH  = 3'd5;

  // Configuration registers
  logic [HIST_W-1:0] down_mask_q, up_mask_q;
  logic [CNT_W-1:0]  hold_thr_q, turbo_thr_q, slow_rate_q, turbo_rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_mask_q    <= DOWN_MASK_RST;
      up_mask_q      <= UP_MASK_RST;
      hold_thr_q     <= HOLD_THR_RST;
      turbo_thr_q    <= TURBO_THR_RST;
      slow_rate_q    <= SLOW_RATE_RST;
      turbo_rate_q   <= TURBO_RATE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DOWN_MASK:    down_mask_q    <= cfg_wdata_i[HIST_W-1:0];
        REG_UP_MASK:      up_mask_q      <= cfg_wdata_i[HIST_W-1:0];
        REG_HOLD_THR:     hold_thr_q     <= cfg_wdata_i;
        REG_TURBO_THR:    turbo_thr_q    <= cfg_wdata_i;
        REG_SLOW_RATE:    slow_rate_q    <= cfg_wdata_i;
        REG_TURBO_RATE:   turbo_rate_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer state
  logic [2:0]          state_q, state_d;
  logic [AW-1:0]       key_q;
  logic [NUM_KEYS-1:0] raw_sh_q;

  // Evaluated key result waiting for write-back
  key_state_t          st_q;
  logic                fire_q;
  logic [KIND_W-1:0]   kind_q;

  // One event held back until we know whether it is the last of the tick
  logic                 pend_valid_q;
  logic [KEY_IDX_W-1:0] pend_key_q;
  logic [KIND_W-1:0]    pend_kind_q;

  // Output register
  logic                 out_valid_q;
  logic [KEY_IDX_W-1:0] out_key_q;
  logic [KIND_W-1:0]    out_kind_q;
  logic                 out_last_q;

  key_state_t rd_st;
  mod_req_t   mod_req;
  mod_rsp_t   mod_rsp;

  logic             accept;
  logic             can_push;
  logic             commit_go;
  logic             push_mid;
  logic             push_last;
  logic [HIST_W-1:0] hist_new;
  logic [CNT_W-1:0] cnt_inc;
  logic             press_hit, rel_hit, at_thr;
  logic [CNT_W-1:0] rate_sel;
  logic             rpt_check;

  assign accept        = tick_in.valid && (state_q == S_IDLE);
  assign tick_in.ready = (state_q == S_IDLE);
  assign can_push      = !out_valid_q || evt_out.ready;

  // Per-key evaluation on the word just read
  always_comb begin
    hist_new  = {rd_st.hist[HIST_W-2:0], raw_sh_q[0]};
    cnt_inc   = rd_st.count + 1'b1;
    press_hit = (hist_new & down_mask_q) == down_mask_q;
    rel_hit   = (hist_new & up_mask_q) == '0;
    at_thr    = cnt_inc >= hold_thr_q;
    rate_sel  = (cnt_inc > turbo_thr_q) ? turbo_rate_q : slow_rate_q;
    rpt_check = (state_q == S_EVAL) && rd_st.held && !rel_hit && at_thr;
  end

  // A zero rate counts as one
  assign mod_req.start    = rpt_check;
  assign mod_req.dividend = cnt_inc - hold_thr_q;
  assign mod_req.divisor  = (rate_sel == '0) ? CNT_W'(1) : rate_sel;

  // Write-back waits only when a new event must displace a pending one
  assign commit_go = (state_q == S_COMMIT) && !(fire_q && pend_valid_q && !can_push);
  assign push_mid  = commit_go && fire_q && pend_valid_q;
  assign push_last = (state_q == S_FLUSH) && pend_valid_q && can_push;

  // Next-state logic
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (accept) state_d = S_READ;
      S_READ:   state_d = S_EVAL;
      S_EVAL:   state_d = rpt_check ? S_MODW : S_COMMIT;
      S_MODW:   if (mod_rsp.done) state_d = S_COMMIT;
      S_COMMIT: begin
        if (commit_go) state_d = (key_q == LAST_KEY) ? S_FLUSH : S_READ;
      end
      S_FLUSH:  if (!pend_valid_q || can_push) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      fire_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (push_mid || push_last) begin
        out_valid_q <= 1'b1;
      end else if (evt_out.ready) begin
        out_valid_q <= 1'b0;
      end
      if (commit_go && fire_q) begin
        pend_valid_q <= 1'b1;
      end else if (push_last) begin
        pend_valid_q <= 1'b0;
      end
      if (state_q == S_EVAL) begin
        fire_q <= (!rd_st.held && press_hit) || (rd_st.held && rel_hit);
      end else if (state_q == S_MODW && mod_rsp.done) begin
        fire_q <= mod_rsp.zero;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q    <= '0;
      raw_sh_q <= NUM_KEYS'(tick_in.raw_pressed);
    end else if (commit_go) begin
      key_q    <= key_q + 1'b1;
      raw_sh_q <= raw_sh_q >> 1;
    end

    if (state_q == S_EVAL) begin
      st_q.hist <= hist_new;
      if (!rd_st.held) begin
        st_q.held  <= press_hit;
        st_q.count <= press_hit ? '0 : rd_st.count;
        kind_q     <= EV_PRESS;
      end else if (rel_hit) begin
        st_q.held  <= 1'b0;
        st_q.count <= '0;
        kind_q     <= EV_RELEASE;
      end else begin
        st_q.held  <= 1'b1;
        st_q.count <= cnt_inc;
        kind_q     <= EV_REPEAT;
      end
    end

    if (commit_go && fire_q) begin
      pend_key_q  <= KEY_IDX_W'(key_q);
      pend_kind_q <= kind_q;
    end

    if (push_mid || push_last) begin
      out_key_q  <= pend_key_q;
      out_kind_q <= pend_kind_q;
      out_last_q <= push_last;
    end
  end

  // Keys are read and written back one at a time, so an entry is never
  // read while its own write is still in flight.
  kdar_state_mem #(
    .NUM_KEYS (NUM_KEYS),
    .AW       (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (state_q == S_READ),
    .raddr_i (key_q),
    .we_i    (commit_go),
    .waddr_i (key_q),
    .wdata_i (st_q),
    .rdata_o (rd_st)
  );

  kdar_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  assign evt_out.valid        = out_valid_q;
  assign evt_out.key_id       = out_key_q;
  assign evt_out.event_kind   = out_kind_q;
  assign evt_out.last_of_tick = out_last_q;

endmodule

`default_nettype wire

@@ rtl/core/kdar_checker.sv @@
// Port-level checks for the keypad debounce core, bound to the top level.
`default_nettype none

module kdar_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [kdar_pkg::KEY_IDX_W-1:0] out_key_i,
  input logic [kdar_pkg::KIND_W-1:0]    out_kind_i,
  input logic                           out_last_i
);
  import kdar_pkg::*;

  // A stalled event stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_key_i)
      && $stable(out_kind_i) && $stable(out_last_i))
    else $error("stalled event changed");

  // Only the three event kinds are produced
  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_kind_i == EV_PRESS || out_kind_i == EV_REPEAT
      || out_kind_i == EV_RELEASE))
    else $error("illegal event kind");

  // A tick occupies the key pass: ready stays low after a tick is taken
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i ##1 !in_ready_i ##1 !in_ready_i)
    else $error("tick taken during key pass");

endmodule

bind keypad_debounce_auto_repeat_core kdar_checker u_kdar_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (tick_in.valid),
  .in_ready_i  (tick_in.ready),
  .out_valid_i (evt_out.valid),
  .out_ready_i (evt_out.ready),
  .out_key_i   (evt_out.key_id),
  .out_kind_i  (evt_out.event_kind),
  .out_last_i  (evt_out.last_of_tick)
);

`default_nettype wire
